>>> hw/rtl/rmr_pkg.sv
// Package for the radio message reassembler: constants, codes and the
// front-to-back word type. No dependencies.
package rmr_pkg;
	localparam int MaxMessage = 1024;
	localparam int MaxFragmentData = 245;
	localparam int MaxFragments = 16;
	localparam int MaxPacket = 255;
	localparam int HdrLen = 10;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_FAIL = 2'd1;
	localparam logic [1:0] CMD_FETCH = 2'd2;

	localparam logic [2:0] ST_FRAG_OK = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_BAD_HDR = 3'd2;
	localparam logic [2:0] ST_SEQ_ERR = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;
	localparam logic [2:0] ST_CRC_ERR = 3'd5;
	localparam logic [2:0] ST_RADIO_FAIL = 3'd6;
	localparam logic [2:0] ST_NOTHING = 3'd7;

	// One word from the front part to the back part.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
		logic end_of_packet;
	} rmr_word_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage

>>> hw/rtl/rmr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rmr_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/rmr_front.sv
// Front part: accepts input words into a two-entry queue.
// Depends on rmr_pkg.
module rmr_front import rmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rmr_word_t in_word,
	output logic q_valid,
	input logic q_pop,
	output rmr_word_t q_word
);
	rmr_word_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_word;
	end
endmodule

>>> hw/rtl/rmr_back.sv
// Back part: header capture, sequence checks, buffer writes, CRC and readout.
// Depends on rmr_pkg and rmr_ram.
module rmr_back import rmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [10:0] cfg_data,
	input logic q_valid,
	output logic q_pop,
	input rmr_word_t q_word,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [7:0] data,
	output logic last,
	output logic [10:0] message_length
);
	localparam int AW = $clog2(MaxMessage);

	logic [7:0] hdr_q [HdrLen];
	logic [7:0] pcnt_q;
	logic bad_q, ovf_q;
	logic [10:0] brx_q, etot_q, rdpos_q, rlen_q, maxlen_q;
	logic [15:0] ecrc_q, id_q, crc_q;
	logic [7:0] ecnt_q, nidx_q, fver_q;
	logic asm_q, ready_q;

	// Output register; a fetch result takes its byte from the registered RAM read data.
	logic ov_q, ofetch_q, olast_q;
	logic [2:0] ost_q;
	logic [10:0] olen_q;
	logic [7:0] rdata;

	logic advance, fire;
	assign advance = !ov_q || !out_stall;
	assign q_pop = q_valid && advance;
	assign fire = q_pop;

	assign out_valid = ov_q;
	assign status = ost_q;
	assign data = ofetch_q ? rdata : 8'd0;
	assign last = olast_q;
	assign message_length = olen_q;

	// Header view with the last header byte merged in when it is being taken this cycle.
	logic [7:0] h [HdrLen];
	logic is_hdr_last;
	always_comb begin
		for (int i = 0; i < HdrLen; i++) h[i] = hdr_q[i];
		is_hdr_last = (pcnt_q == 8'(HdrLen - 1));
		if (is_hdr_last) h[HdrLen-1] = q_word.rx_byte;
	end

	function automatic logic hdr_ok(input logic [7:0] v0, input logic [15:0] tot,
		input logic [7:0] idx, input logic [7:0] cnt, input logic [7:0] fl,
		input logic [7:0] ver);
		return (v0 == ver) && (tot != 16'd0) && (tot <= 16'(MaxMessage)) &&
			(cnt != 8'd0) && (cnt <= 8'(MaxFragments)) && (idx < cnt) &&
			(fl != 8'd0) && (fl <= 8'(MaxFragmentData));
	endfunction

	logic [15:0] h_id, h_tot, h_crc;
	logic hok, seq_cont, seq_start;
	always_comb begin
		h_id = {h[1], h[2]};
		h_tot = {h[3], h[4]};
		h_crc = {h[5], h[6]};
		hok = hdr_ok(h[0], h_tot, h[7], h[8], h[9], fver_q);
		seq_start = (h[7] == 8'd0) && ({8'd0, h[9]} <= h_tot);
		seq_cont = (h_id == id_q) && (h_tot == {5'd0, etot_q}) && (h_crc == ecrc_q) &&
			(h[8] == ecnt_q) && (h[7] == nidx_q) &&
			({1'b0, brx_q} + {4'd0, h[9]} <= {1'b0, etot_q});
	end

	// Payload write.
	logic [7:0] off;
	logic [11:0] addr;
	logic wr_pay;
	always_comb begin
		off = pcnt_q - 8'(HdrLen);
		addr = {1'b0, brx_q} + {4'd0, off};
		wr_pay = fire && q_word.cmd == CMD_BYTE && pcnt_q < 8'(MaxPacket) &&
			pcnt_q >= 8'(HdrLen) && !bad_q && off < hdr_q[9] &&
			addr < 12'(MaxMessage);
	end

	// While a fetched byte waits at the output, keep reading its address so the
	// data stays put; the position register has already moved past it.
	logic [AW-1:0] raddr;
	assign raddr = (ov_q && ofetch_q && out_stall) ? AW'(rdpos_q - 11'd1) : AW'(rdpos_q);

	rmr_ram #(.Width(8), .Depth(MaxMessage)) u_ram (
		.clk(clk), .we(wr_pay), .waddr(AW'(addr)), .wdata(q_word.rx_byte),
		.raddr(raddr), .rdata(rdata)
	);

	// Packet end evaluation; the CRC includes a payload byte taken this cycle.
	logic [2:0] pe_st;
	logic [10:0] brx_n;
	logic [7:0] nidx_n;
	logic [7:0] pcnt_n;
	logic [15:0] crc_n;
	logic end_hok;
	always_comb begin
		pcnt_n = (pcnt_q < 8'(MaxPacket)) ? pcnt_q + 8'd1 : pcnt_q;
		end_hok = hdr_ok(h[0], h_tot, h[7], h[8], h[9], fver_q);
		brx_n = brx_q + {3'd0, h[9]};
		nidx_n = nidx_q + 8'd1;
		crc_n = wr_pay ? crc_update(crc_q, q_word.rx_byte) : crc_q;
		pe_st = ST_FRAG_OK;
		if (ovf_q || pcnt_q >= 8'(MaxPacket)) pe_st = ST_RADIO_FAIL;
		else if (pcnt_n < 8'(HdrLen) || !end_hok || pcnt_n != 8'(HdrLen) + h[9])
			pe_st = ST_BAD_HDR;
		else if (is_hdr_last ? !(hok && (asm_q ? seq_cont : seq_start)) : bad_q)
			pe_st = ST_SEQ_ERR;
		else if (nidx_n != (is_hdr_last && !asm_q ? h[8] : ecnt_q)) pe_st = ST_FRAG_OK;
		else if (brx_n != (is_hdr_last && !asm_q ? h_tot[10:0] : etot_q))
			pe_st = ST_SEQ_ERR;
		else if ((is_hdr_last && !asm_q ? h_tot[10:0] : etot_q) > maxlen_q)
			pe_st = ST_TOO_LONG;
		else if ((is_hdr_last && !asm_q ? CrcInit : crc_n) !=
			(is_hdr_last && !asm_q ? h_crc : ecrc_q)) pe_st = ST_CRC_ERR;
		else pe_st = ST_COMPLETE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HdrLen; i++) hdr_q[i] <= 8'd0;
			pcnt_q <= 8'd0; bad_q <= 1'b0; ovf_q <= 1'b0;
			brx_q <= 11'd0; etot_q <= 11'd0; ecrc_q <= 16'd0; id_q <= 16'd0;
			ecnt_q <= 8'd0; nidx_q <= 8'd0; asm_q <= 1'b0; crc_q <= CrcInit;
			ready_q <= 1'b0; rdpos_q <= 11'd0; rlen_q <= 11'd0;
			maxlen_q <= 11'd1024; fver_q <= 8'd1;
			ov_q <= 1'b0; ofetch_q <= 1'b0; olast_q <= 1'b0;
			ost_q <= ST_NOTHING; olen_q <= 11'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'b0) maxlen_q <= cfg_data;
				else fver_q <= cfg_data[7:0];
			end
			if (!out_stall) ov_q <= 1'b0;
			if (fire) begin
				case (q_word.cmd)
					CMD_BYTE: begin
						logic st_ok;
						st_ok = 1'b0;
						if (pcnt_q >= 8'(MaxPacket)) ovf_q <= 1'b1;
						else begin
							pcnt_q <= pcnt_q + 8'd1;
							if (pcnt_q < 8'(HdrLen)) begin
								hdr_q[pcnt_q[3:0]] <= q_word.rx_byte;
								if (is_hdr_last) begin
									if (hok && !asm_q && seq_start) begin
										st_ok = 1'b1;
										asm_q <= 1'b1; brx_q <= 11'd0;
										etot_q <= h_tot[10:0]; ecrc_q <= h_crc;
										id_q <= h_id; ecnt_q <= h[8]; nidx_q <= 8'd0;
										crc_q <= CrcInit; ready_q <= 1'b0;
										rdpos_q <= 11'd0; rlen_q <= 11'd0;
									end else if (hok && asm_q && seq_cont) st_ok = 1'b1;
									bad_q <= !st_ok;
								end
							end else if (wr_pay) crc_q <= crc_n;
						end
						if (q_word.end_of_packet) begin
							pcnt_q <= 8'd0; bad_q <= 1'b0; ovf_q <= 1'b0;
							ov_q <= 1'b1; ofetch_q <= 1'b0; olast_q <= 1'b0;
							ost_q <= pe_st;
							olen_q <= (pe_st == ST_COMPLETE) ? brx_n : 11'd0;
							if (pe_st == ST_FRAG_OK) begin
								brx_q <= brx_n; nidx_q <= nidx_n;
							end else begin
								brx_q <= 11'd0; etot_q <= 11'd0; ecrc_q <= 16'd0;
								id_q <= 16'd0; ecnt_q <= 8'd0; nidx_q <= 8'd0;
								asm_q <= 1'b0; crc_q <= CrcInit;
							end
							if (pe_st == ST_COMPLETE) begin
								ready_q <= 1'b1; rlen_q <= brx_n; rdpos_q <= 11'd0;
							end
						end
					end
					CMD_FAIL: begin
						brx_q <= 11'd0; etot_q <= 11'd0; ecrc_q <= 16'd0;
						id_q <= 16'd0; ecnt_q <= 8'd0; nidx_q <= 8'd0;
						asm_q <= 1'b0; crc_q <= CrcInit;
						pcnt_q <= 8'd0; bad_q <= 1'b0; ovf_q <= 1'b0;
						ov_q <= 1'b1; ofetch_q <= 1'b0; olast_q <= 1'b0;
						ost_q <= ST_RADIO_FAIL; olen_q <= 11'd0;
					end
					CMD_FETCH: begin
						ov_q <= 1'b1;
						if (!ready_q || rdpos_q >= rlen_q ||
								{5'd0, rdpos_q} >= 16'(MaxMessage)) begin
							ready_q <= 1'b0; ofetch_q <= 1'b0; olast_q <= 1'b0;
							ost_q <= ST_NOTHING; olen_q <= 11'd0;
						end else begin
							ofetch_q <= 1'b1; ost_q <= ST_COMPLETE; olen_q <= rlen_q;
							olast_q <= (rdpos_q + 11'd1 >= rlen_q);
							rdpos_q <= rdpos_q + 11'd1;
							if (rdpos_q + 11'd1 >= rlen_q) ready_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

>>> hw/rtl/radio_message_reassembler.sv
// Radio message reassembler: takes one word per cycle (a packet byte, a radio
// fail event or a fetch) while the output is not stalled; the front queue
// holds two words. A result is registered at the output after its word has
// passed the front queue, and a stalled result stalls the input once the
// queue is full. Depends on rmr_pkg, rmr_front and rmr_back.
module radio_message_reassembler import rmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [10:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] cmd,
	input logic [7:0] rx_byte,
	input logic end_of_packet,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [7:0] data,
	output logic last,
	output logic [10:0] message_length
);
	rmr_word_t in_word, q_word;
	logic q_valid, q_pop;

	assign in_word = '{cmd: cmd, rx_byte: rx_byte, end_of_packet: end_of_packet};

	rmr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
	);

	rmr_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .data(data),
		.last(last), .message_length(message_length)
	);
endmodule
